// File: hdl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, constants and helpers for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int HEAP_BYTES   = 16384;
	localparam int HEADER_BYTES = 8;
	localparam int ALIGN_BYTES  = 4;
	localparam int ADDR_W       = 14;
	localparam int SIZE_W       = 15;

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	typedef struct packed {
		logic              free;
		logic [SIZE_W-1:0] size;
	} hdr_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		hdr_t              wdata;
	} mem_req_t;

	// add two block sizes, clip at the heap size
	function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
		input logic [SIZE_W-1:0] b);
		logic [SIZE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s > (SIZE_W+1)'(HEAP_BYTES))
			return SIZE_W'(HEAP_BYTES);
		return s[SIZE_W-1:0];
	endfunction

	function automatic logic [SIZE_W-1:0] payload_of(input logic [SIZE_W-1:0] s);
		if (s > SIZE_W'(HEADER_BYTES))
			return s - SIZE_W'(HEADER_BYTES);
		return '0;
	endfunction

endpackage

// File: hdl/ffha_hdr_ram.sv
// ----------------------------------------------------------------------------
// ffha_hdr_ram
// Header store: one entry per byte offset, single port, registered read.
// ----------------------------------------------------------------------------
module ffha_hdr_ram (
	input  logic              clk,
	input  ffha_pkg::mem_req_t req,
	output ffha_pkg::hdr_t    rdata
);

	ffha_pkg::hdr_t mem [ffha_pkg::HEAP_BYTES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata <= mem[req.addr];
	end

endmodule

// File: hdl/ffha_engine.sv
// ----------------------------------------------------------------------------
// ffha_engine
// Command sequencer: walks the block list in the header store and rewrites it.
// ----------------------------------------------------------------------------
module ffha_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     command,
	input  logic [ffha_pkg::SIZE_W-1:0]    request_bytes,
	input  logic [ffha_pkg::ADDR_W-1:0]    payload_offset,
	input  logic                           cfg_valid,
	input  logic [ffha_pkg::SIZE_W-1:0]    cfg_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ffha_pkg::ADDR_W-1:0]    result_offset,
	output logic [ffha_pkg::SIZE_W-1:0]    payload_bytes,
	output logic                           status,
	output ffha_pkg::mem_req_t             mem_req,
	input  ffha_pkg::hdr_t                 mem_rdata
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_A_WALK, ST_A_CHK, ST_A_SPLIT,
		ST_F_RD, ST_F_MARK, ST_F_P0, ST_F_P0C, ST_F_PW, ST_F_PC,
		ST_F_NEXT, ST_F_NC, ST_Q_RD, ST_Q_CHK, ST_DONE
	} state_t;

	localparam int AW = ffha_pkg::ADDR_W;
	localparam int SW = ffha_pkg::SIZE_W;

	state_t          state_q;
	logic [SW:0]     need_q;
	logic [SW:0]     cur_q;
	logic [AW-1:0]   pos_q;
	logic [SW-1:0]   psz_q;
	logic [AW-1:0]   prev_q;
	ffha_pkg::hdr_t  prev_ent_q;
	logic [SW-1:0]   top_q;
	logic [SW-1:0]   limit_q;
	logic [AW-1:0]   res_off_q;
	logic [SW-1:0]   res_pay_q;
	logic            res_st_q;
	logic            out_valid_q;
	logic [AW-1:0]   out_off_q;
	logic [SW-1:0]   out_pay_q;
	logic            out_st_q;

	logic            in_acc;
	logic [SW:0]     need_in;
	logic [SW-1:0]   off_m;
	logic            hdr_ok;
	logic [SW-1:0]   lim;
	logic            app_oom;
	logic            walk_end;
	logic            hit;
	logic            split;
	logic [SW-1:0]   take_size;
	logic [SW-1:0]   prev_merge;
	logic [SW:0]     nxt;
	logic            out_load;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign need_in  = (({1'b0, request_bytes} + (SW+1)'(ffha_pkg::ALIGN_BYTES - 1))
		& ~(SW+1)'(ffha_pkg::ALIGN_BYTES - 1)) + (SW+1)'(ffha_pkg::HEADER_BYTES);
	assign off_m    = {1'b0, payload_offset} - SW'(ffha_pkg::HEADER_BYTES);
	assign hdr_ok   = ({1'b0, payload_offset} >= SW'(ffha_pkg::HEADER_BYTES)) &&
		(off_m < top_q);
	assign lim      = (limit_q < SW'(ffha_pkg::HEAP_BYTES)) ? limit_q :
		SW'(ffha_pkg::HEAP_BYTES);
	assign app_oom  = (need_q > {1'b0, lim}) || ({1'b0, top_q} > ({1'b0, lim} - need_q));
	assign walk_end = cur_q >= {1'b0, top_q};
	assign hit      = mem_rdata.free && ({1'b0, mem_rdata.size} >= need_q);
	assign split    = ({1'b0, mem_rdata.size} > need_q) &&
		(({1'b0, mem_rdata.size} - need_q) > (SW+1)'(ffha_pkg::HEADER_BYTES));
	assign take_size  = split ? need_q[SW-1:0] : mem_rdata.size;
	assign prev_merge = ffha_pkg::sat_add(prev_ent_q.size, psz_q);
	assign nxt        = {2'b0, pos_q} + {1'b0, psz_q};
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// header store requests
	always_comb begin
		mem_req = '0;
		case (state_q)
			ST_A_WALK: begin
				if (walk_end) begin
					mem_req.we    = !app_oom;
					mem_req.addr  = top_q[AW-1:0];
					mem_req.wdata = '{free: 1'b0, size: need_q[SW-1:0]};
				end else begin
					mem_req.addr = cur_q[AW-1:0];
				end
			end
			ST_A_CHK: begin
				if (mem_rdata.size == '0) begin
					mem_req.we    = !app_oom;
					mem_req.addr  = top_q[AW-1:0];
					mem_req.wdata = '{free: 1'b0, size: need_q[SW-1:0]};
				end else if (hit) begin
					mem_req.we    = 1'b1;
					mem_req.addr  = cur_q[AW-1:0];
					mem_req.wdata = '{free: 1'b0, size: take_size};
				end
			end
			ST_A_SPLIT: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = AW'(cur_q + need_q);
				mem_req.wdata = '{free: 1'b1, size: psz_q};
			end
			ST_F_RD, ST_Q_RD: mem_req.addr = pos_q;
			ST_F_MARK: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = pos_q;
				mem_req.wdata = '{free: 1'b1, size: mem_rdata.size};
			end
			ST_F_P0: mem_req.addr = '0;
			ST_F_PW: begin
				if (!walk_end && cur_q == {2'b0, pos_q}) begin
					mem_req.we    = prev_ent_q.free;
					mem_req.addr  = prev_q;
					mem_req.wdata = '{free: 1'b1, size: prev_merge};
				end else begin
					mem_req.addr = cur_q[AW-1:0];
				end
			end
			ST_F_NEXT: mem_req.addr = nxt[AW-1:0];
			ST_F_NC: begin
				mem_req.we    = mem_rdata.free;
				mem_req.addr  = pos_q;
				mem_req.wdata = '{free: 1'b1,
					size: ffha_pkg::sat_add(psz_q, mem_rdata.size)};
			end
			default: mem_req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			top_q       <= '0;
			limit_q     <= SW'(ffha_pkg::HEAP_BYTES);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_off_q   <= res_off_q;
				out_pay_q   <= res_pay_q;
				out_st_q    <= res_st_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						res_off_q <= '0;
						res_pay_q <= '0;
						res_st_q  <= 1'b0;
						need_q    <= need_in;
						cur_q     <= '0;
						pos_q     <= off_m[AW-1:0];
						case (command)
							ffha_pkg::CMD_ALLOC: state_q <= ST_A_WALK;
							ffha_pkg::CMD_FREE:  state_q <= hdr_ok ? ST_F_RD : ST_DONE;
							ffha_pkg::CMD_QUERY: state_q <= hdr_ok ? ST_Q_RD : ST_DONE;
							default:             state_q <= ST_DONE;
						endcase
					end
				end
				ST_A_WALK, ST_A_CHK: begin
					if ((state_q == ST_A_WALK && walk_end) ||
						(state_q == ST_A_CHK && mem_rdata.size == '0)) begin
						// append at the top of the heap
						if (app_oom) begin
							res_st_q <= 1'b1;
						end else begin
							res_off_q <= AW'(top_q + SW'(ffha_pkg::HEADER_BYTES));
							res_pay_q <= need_q[SW-1:0] - SW'(ffha_pkg::HEADER_BYTES);
							top_q     <= SW'(need_q + {1'b0, top_q});
						end
						state_q <= ST_DONE;
					end else if (state_q == ST_A_WALK) begin
						state_q <= ST_A_CHK;
					end else if (hit) begin
						res_off_q <= AW'(cur_q + (SW+1)'(ffha_pkg::HEADER_BYTES));
						res_pay_q <= ffha_pkg::payload_of(take_size);
						psz_q     <= SW'({1'b0, mem_rdata.size} - need_q);
						state_q   <= split ? ST_A_SPLIT : ST_DONE;
					end else begin
						cur_q   <= cur_q + {1'b0, mem_rdata.size};
						state_q <= ST_A_WALK;
					end
				end
				ST_A_SPLIT: state_q <= ST_DONE;
				ST_F_RD:    state_q <= ST_F_MARK;
				ST_F_MARK: begin
					psz_q   <= mem_rdata.size;
					state_q <= ST_F_P0;
				end
				ST_F_P0: state_q <= ST_F_P0C;
				ST_F_P0C: begin
					prev_q     <= '0;
					prev_ent_q <= mem_rdata;
					cur_q      <= {1'b0, mem_rdata.size};
					state_q    <= (mem_rdata.size == '0) ? ST_F_NEXT : ST_F_PW;
				end
				ST_F_PW: begin
					if (walk_end) begin
						state_q <= ST_F_NEXT;
					end else if (cur_q == {2'b0, pos_q}) begin
						// merge into a free previous block
						if (prev_ent_q.free) begin
							pos_q <= prev_q;
							psz_q <= prev_merge;
						end
						state_q <= ST_F_NEXT;
					end else begin
						state_q <= ST_F_PC;
					end
				end
				ST_F_PC: begin
					if (mem_rdata.size == '0) begin
						state_q <= ST_F_NEXT;
					end else begin
						prev_q     <= cur_q[AW-1:0];
						prev_ent_q <= mem_rdata;
						cur_q      <= cur_q + {1'b0, mem_rdata.size};
						state_q    <= ST_F_PW;
					end
				end
				ST_F_NEXT: state_q <= (nxt < {1'b0, top_q}) ? ST_F_NC : ST_DONE;
				ST_F_NC:   state_q <= ST_DONE;
				ST_Q_RD:   state_q <= ST_Q_CHK;
				ST_Q_CHK: begin
					res_pay_q <= ffha_pkg::payload_of(mem_rdata.size);
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign result_offset = out_off_q;
	assign payload_bytes = out_pay_q;
	assign status        = out_st_q;

endmodule

// File: hdl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over an implicit block list kept in a header store.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | word
// in      | input     | in_valid/in_stall  | command, request_bytes, payload_offset
// out     | output    | out_valid/out_stall| result_offset, payload_bytes, status
// cfg     | input     | cfg_valid/cfg_ready| cfg_data (heap_limit_bytes)
//
// Allocate walks the block list, appending at the heap top if no free block
// fits; free merges the block with free neighbours; query reads its header.
// All share the one header store port (one access per cycle, registered read).
// Reset clears the heap top and sets the limit to the full heap; the header
// store needs no clearing.
// A stalled output holds its word; the next command is taken meanwhile and
// waits in its last cycle until the output word is taken.
module first_fit_heap_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  command,
	input  logic [ffha_pkg::SIZE_W-1:0] request_bytes,
	input  logic [ffha_pkg::ADDR_W-1:0] payload_offset,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ffha_pkg::SIZE_W-1:0] cfg_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ffha_pkg::ADDR_W-1:0] result_offset,
	output logic [ffha_pkg::SIZE_W-1:0] payload_bytes,
	output logic                        status
);

	ffha_pkg::mem_req_t mem_req;
	ffha_pkg::hdr_t     mem_rdata;

	assign cfg_ready = 1'b1;

	ffha_hdr_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	ffha_engine u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.request_bytes  (request_bytes),
		.payload_offset (payload_offset),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_offset  (result_offset),
		.payload_bytes  (payload_bytes),
		.status         (status),
		.mem_req        (mem_req),
		.mem_rdata      (mem_rdata)
	);

endmodule

// File: hdl/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks for the first-fit heap allocator.
// ----------------------------------------------------------------------------
module ffha_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [ffha_pkg::ADDR_W-1:0] result_offset,
	input logic [ffha_pkg::SIZE_W-1:0] payload_bytes,
	input logic                        status
);

	// one command at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_offset) &&
		$stable(payload_bytes) && $stable(status))
		else $error("stalled output word changed");

	a_oom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> result_offset == '0 && payload_bytes == '0)
		else $error("out of memory word carries data");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.result_offset (result_offset),
	.payload_bytes (payload_bytes),
	.status        (status)
);
